@@ hw/rtl/multiword_delta_codec_macros.svh @@
// Assertion macros used by the codec's top-level RTL file.
`ifndef MULTIWORD_DELTA_CODEC_MACROS_SVH
`define MULTIWORD_DELTA_CODEC_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multiword_delta_codec: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("multiword_delta_codec: next-cycle check failed");

`endif

@@ hw/rtl/mdc_pkg.sv @@
// Types and constants of the multiword delta codec.
package mdc_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NUM_WORDS  = 3;
  localparam int unsigned KEY_W      = WORD_W * NUM_WORDS;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  typedef enum logic [1:0] {
    WIDTH_32  = 2'd0,
    WIDTH_64  = 2'd1,
    WIDTH_128 = 2'd2,
    WIDTH_192 = 2'd3
  } width_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_MODE  = 2'd0,
    CFG_DECODE_MODE = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    width_mode_e width_mode;
    logic        decode_mode;
  } mode_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } key_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             order_error;
    logic             last;
  } res_item_t;

  typedef struct packed {
    res_item_t        res;
    logic [KEY_W-1:0] prev_next;
    logic             err_next;
  } alu_out_t;

endpackage

@@ hw/rtl/mdc_channel_if.sv @@
// Valid/ready channel interfaces for keys in and results out.
interface mdc_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_low;
  logic [63:0] word_mid;
  logic [63:0] word_high;
  logic        last_of_block;

  modport source (output valid, output word_low, output word_mid, output word_high,
                  output last_of_block, input ready);
  modport sink (input valid, input word_low, input word_mid, input word_high,
                input last_of_block, output ready);
endinterface

interface mdc_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_low;
  logic [63:0] out_mid;
  logic [63:0] out_high;
  logic        order_error;
  logic        out_last;

  modport source (output valid, output out_low, output out_mid, output out_high,
                  output order_error, output out_last, input ready);
  modport sink (input valid, input out_low, input out_mid, input out_high,
                input order_error, input out_last, output ready);
endinterface

@@ hw/rtl/multiword_delta_codec.sv @@
// A result passes from the input register through the 192-bit add/subtract into the
// result register; a stall at the output holds it in the input register.
// Throughput: one key per cycle while the receiver takes results; the add/subtract
// updates the stored previous value each time an item moves into the result register.
// Reset clears modes (32-bit encode), previous value, error flag and valid bits.
// Previous value and error flag also clear after each item marked last.
`include "multiword_delta_codec_macros.svh"

module multiword_delta_codec
  import mdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mdc_key_if.sink               key_i,
  mdc_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  mode_t            mode_q, mode_d;
  logic [KEY_W-1:0] prev_q;
  logic             err_q;
  logic             s1_valid;
  key_item_t        s1_item;
  logic             advance;
  alu_out_t         alu_out;
  logic             out_valid_q, out_valid_d;
  res_item_t        out_q;

  always_comb begin
    mode_d = mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH_MODE:  mode_d.width_mode  = width_mode_e'(cfg_wdata_i);
        CFG_DECODE_MODE: mode_d.decode_mode = cfg_wdata_i[0];
        default:         mode_d = mode_q;
      endcase
    end
  end

  // The held item moves into the result register whenever that register frees up.
  assign advance = s1_valid && (!out_valid_q || res_o.ready);

  mdc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (key_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  mdc_alu u_alu (
    .mode_i (mode_q),
    .item_i (s1_item),
    .prev_i (prev_q),
    .err_i  (err_q),
    .out_o  (alu_out)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '{width_mode: WIDTH_32, decode_mode: 1'b0};
      prev_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        prev_q <= alu_out.prev_next;
        err_q  <= alu_out.err_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= alu_out.res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_low     = out_q.key[WORD_W-1:0];
  assign res_o.out_mid     = out_q.key[2*WORD_W-1:WORD_W];
  assign res_o.out_high    = out_q.key[3*WORD_W-1:2*WORD_W];
  assign res_o.order_error = out_q.order_error;
  assign res_o.out_last    = out_q.last;

  `MDC_ASSERT_NEXT(a_last_clears_state, clk_i, rst_ni, advance && s1_item.last, (prev_q == '0) && !err_q)
  `MDC_ASSERT_NEXT(a_error_sticky, clk_i, rst_ni, err_q && !(advance && s1_item.last), err_q)
  `MDC_ASSERT_NEXT(a_decode_no_new_error, clk_i, rst_ni, advance && mode_q.decode_mode && !err_q, !err_q)
  `MDC_ASSERT_NEXT(a_narrow_result_masked, clk_i, rst_ni, advance && (mode_q.width_mode == WIDTH_32), out_q.key[KEY_W-1:WORD_W/2] == '0)

endmodule

@@ hw/rtl/mdc_in_stage.sv @@
// Input register stage of the codec.
module mdc_in_stage
  import mdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mdc_key_if.sink   key_i,
  input  logic      advance_i,
  output logic      valid_o,
  output key_item_t item_o
);

  logic      valid_q, valid_d;
  key_item_t item_q;
  logic      take;

  // A new item enters when the stage is empty or its item moves on.
  assign key_i.ready = !valid_q || advance_i;
  assign take        = key_i.valid && key_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{key: {key_i.word_high, key_i.word_mid, key_i.word_low},
                  last: key_i.last_of_block};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/mdc_alu.sv @@
// Masked 192-bit subtract or add with order check and state update.
module mdc_alu
  import mdc_pkg::*;
(
  input  mode_t            mode_i,
  input  key_item_t        item_i,
  input  logic [KEY_W-1:0] prev_i,
  input  logic             err_i,
  output alu_out_t         out_o
);

  logic [KEY_W-1:0] mask;
  logic [KEY_W-1:0] x;
  logic [KEY_W-1:0] p;
  logic [KEY_W:0]   diff;
  logic [KEY_W-1:0] sum;
  logic [KEY_W-1:0] r;
  logic             err_upd;

  always_comb begin
    case (mode_i.width_mode)
      WIDTH_32:  mask = KEY_W'({(WORD_W/2){1'b1}});
      WIDTH_64:  mask = KEY_W'({WORD_W{1'b1}});
      WIDTH_128: mask = KEY_W'({(2*WORD_W){1'b1}});
      default:   mask = {KEY_W{1'b1}};
    endcase
  end

  assign x = item_i.key & mask;
  assign p = prev_i & mask;

  // The borrow out of the extended subtract is the "key below predecessor" flag.
  assign diff = {1'b0, x} - {1'b0, p};
  assign sum  = x + p;
  assign r    = (mode_i.decode_mode ? sum : diff[KEY_W-1:0]) & mask;

  assign err_upd = err_i || (!mode_i.decode_mode && diff[KEY_W]);

  always_comb begin
    out_o.res.key         = r;
    out_o.res.order_error = err_upd;
    out_o.res.last        = item_i.last;
    out_o.prev_next       = item_i.last ? '0 : (mode_i.decode_mode ? r : x);
    out_o.err_next        = item_i.last ? 1'b0 : err_upd;
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the multiword delta codec: directed table, then random phases.
module tb;
  import mdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RX_HOLD      = 60;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 50;

  localparam logic ENCODE = 1'b0;
  localparam logic DECODE = 1'b1;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [KEY_W-1:0] KEY_ZERO = {KEY_W{1'b0}};
  localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] MASK_32  = {{(KEY_W-32){1'b0}}, {32{1'b1}}};
  localparam logic [KEY_W-1:0] MASK_64  = {{(KEY_W-64){1'b0}}, {64{1'b1}}};
  localparam logic [KEY_W-1:0] MASK_128 = {{(KEY_W-128){1'b0}}, {128{1'b1}}};
  localparam logic [KEY_W-1:0] MID_ONE  = {64'd0, 64'd1, 64'd0};

  typedef struct packed {
    width_mode_e      width;
    logic             decode;
    logic [KEY_W-1:0] key;
    logic             last;
    logic             typed;
    logic [KEY_W-1:0] res_key;
    logic             res_err;
  } step_row_t;

  localparam int unsigned NUM_ROWS = 23;
  localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{WIDTH_32,  ENCODE, ALL_ONES, 1'b0, 1'b1, MASK_32, 1'b0},
    '{WIDTH_32,  ENCODE, KEY_ZERO, 1'b0, 1'b1, 192'd1, 1'b1},
    '{WIDTH_32,  ENCODE, 192'd5, 1'b1, 1'b1, 192'd5, 1'b1},
    '{WIDTH_32,  ENCODE, 192'd3, 1'b1, 1'b1, 192'd3, 1'b0},
    '{WIDTH_192, ENCODE, ALL_ONES, 1'b0, 1'b1, ALL_ONES, 1'b0},
    '{WIDTH_192, ENCODE, KEY_ZERO, 1'b0, 1'b1, 192'd1, 1'b1},
    '{WIDTH_192, ENCODE, MID_ONE, 1'b0, 1'b1, MID_ONE, 1'b1},
    '{WIDTH_192, ENCODE, MASK_64, 1'b0, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_192, ENCODE, {64'd1, 128'd0}, 1'b1, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_128, ENCODE, {{128{1'b1}}, 64'd0}, 1'b0, 1'b1, {64'd0, {64{1'b1}}, 64'd0}, 1'b0},
    '{WIDTH_128, ENCODE, 192'd1, 1'b1, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_64,  DECODE, ALL_ONES, 1'b0, 1'b1, MASK_64, 1'b0},
    '{WIDTH_64,  DECODE, {64'd1, 64'd1, 64'd1}, 1'b0, 1'b1, KEY_ZERO, 1'b0},
    '{WIDTH_64,  DECODE, 192'd7, 1'b1, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_192, DECODE, ALL_ONES, 1'b0, 1'b1, ALL_ONES, 1'b0},
    '{WIDTH_192, DECODE, 192'd1, 1'b0, 1'b1, KEY_ZERO, 1'b0},
    '{WIDTH_192, DECODE, MASK_128, 1'b1, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_32,  ENCODE, 192'd10, 1'b0, 1'b1, 192'd10, 1'b0},
    '{WIDTH_32,  ENCODE, 192'd4, 1'b0, 1'b1, 192'hFFFF_FFFA, 1'b1},
    '{WIDTH_32,  DECODE, 192'd1, 1'b0, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_32,  DECODE, 192'd2, 1'b1, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_192, ENCODE, {64'd5, 64'd6, 64'd7}, 1'b0, 1'b0, KEY_ZERO, 1'b0},
    '{WIDTH_32,  ENCODE, 192'd7, 1'b1, 1'b0, KEY_ZERO, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mdc_key_if key_if ();
  mdc_res_if res_if ();

  multiword_delta_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor state: modes as last written, previous key or running sum, sticky order flag.
  width_mode_e      cur_width = WIDTH_32;
  logic             cur_decode = ENCODE;
  logic [KEY_W-1:0] prev_value = '0;
  logic             order_seen = 1'b0;

  res_item_t due_results[$];
  int        fails = 0;
  int        quiet_cycles = 0;
  logic      burst = 1'b0;
  logic      hold_off = 1'b0;

  function automatic logic [KEY_W-1:0] width_mask(input width_mode_e w);
    case (w)
      WIDTH_32:  return MASK_32;
      WIDTH_64:  return MASK_64;
      WIDTH_128: return MASK_128;
      default:   return ALL_ONES;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Values that sit on the corners of the word arithmetic as well as plain random ones.
  function automatic logic [KEY_W-1:0] shaped_value();
    logic [KEY_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = KEY_ZERO;
      1:       v = ALL_ONES;
      2:       v = rand_key();
      3, 4:    v = rand_key() >> $urandom_range(1, 191);
      default: v = (ALL_ONES >> $urandom_range(0, 191)) - $urandom_range(0, 2);
    endcase
    return v;
  endfunction

  function automatic res_item_t delta_predict(input key_item_t item);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] p;
    res_item_t        res;
    m = width_mask(cur_width);
    x = item.key & m;
    p = prev_value & m;
    if (cur_decode == DECODE) begin
      res.key = (x + p) & m;
      prev_value = res.key;
    end else begin
      if (x < p) order_seen = 1'b1;
      res.key = (x - p) & m;
      prev_value = x;
    end
    res.order_error = order_seen;
    res.last = item.last;
    if (item.last) begin
      prev_value = '0;
      order_seen = 1'b0;
    end
    return res;
  endfunction

  task automatic wait_idle();
    key_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_modes(input width_mode_e w, input logic dec);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WIDTH_MODE;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_idx <= CFG_DECODE_MODE;
    cfg_wdata <= {1'($urandom), dec};
    @(posedge clk_i);
    cfg_idx <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
    cfg_wdata <= 2'($urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_width = w;
    cur_decode = dec;
  endtask

  task automatic send_key(input logic [KEY_W-1:0] k, input logic lst,
                          input logic typed, input res_item_t typed_res);
    int unsigned r;
    int          gap;
    key_item_t   item;
    res_item_t   predicted;
    r = $urandom_range(0, 99);
    if (burst || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 25);
    if (gap > 0) begin
      // Junk on the data lines while valid is low must not matter.
      key_if.valid <= 1'b0;
      key_if.word_low <= {$urandom, $urandom};
      key_if.last_of_block <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    key_if.valid <= 1'b1;
    key_if.word_low <= k[63:0];
    key_if.word_mid <= k[127:64];
    key_if.word_high <= k[191:128];
    key_if.last_of_block <= lst;
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
    item.key = k;
    item.last = lst;
    predicted = delta_predict(item);
    due_results.insert(due_results.size(), typed ? typed_res : predicted);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_item_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $error("result with no item outstanding: %h %h %h", res_if.out_high,
               res_if.out_mid, res_if.out_low);
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("out_low", want.key[63:0], res_if.out_low);
        check_field("out_mid", want.key[127:64], res_if.out_mid);
        check_field("out_high", want.key[191:128], res_if.out_high);
        check_field("order_error", 64'(want.order_error), 64'(res_if.order_error));
        check_field("out_last", 64'(want.last), 64'(res_if.out_last));
      end
    end
  end

  // Receiver pacing: alternating runs of ready and stall, plus one long hold on request.
  initial begin : sink_pacing
    int   run;
    logic level;
    res_if.ready <= 1'b0;
    level = 1'b0;
    run = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        level = 1'b0;
        run = RX_HOLD;
        hold_off = 1'b0;
      end else if (run == 0) begin
        level = !level;
        if (level) run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        else run = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                               : $urandom_range(1, 3);
      end
      run--;
      res_if.ready <= level;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (key_if.valid && key_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    step_row_t        row;
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] chain;
    logic [KEY_W-1:0] stride;
    logic [KEY_W-1:0] k;
    logic             lst;
    logic             open_end;
    int               sent;
    int               blk_len;
    key_if.valid <= 1'b0;
    key_if.word_low <= '0;
    key_if.word_mid <= '0;
    key_if.word_high <= '0;
    key_if.last_of_block <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_WIDTH_MODE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.width != cur_width || row.decode != cur_decode)
        write_modes(row.width, row.decode);
      send_key(row.key, row.last, row.typed,
               res_item_t'{row.res_key, row.res_err, row.last});
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // The first eight phases walk every width in both directions.
      if (ph < 8) write_modes(width_mode_e'(ph[2:1]), ph[0]);
      else write_modes(width_mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      burst = (ph == 5 || ph == 9);
      if (ph == 5) hold_off = 1'b1;
      // Some phases stop mid-block so the next mode inherits the stored value.
      open_end = ($urandom_range(0, 2) == 0);
      mask = width_mask(cur_width);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        blk_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        chain = shaped_value() & mask;
        for (int j = 0; j < blk_len; j++) begin
          if (cur_decode == DECODE || $urandom_range(0, 99) < 12) begin
            k = shaped_value();
          end else begin
            case ($urandom_range(0, 3))
              0:       stride = $urandom_range(0, 3);
              1:       stride = $urandom;
              2:       stride = {$urandom, $urandom};
              default: stride = rand_key() >> $urandom_range(1, 191);
            endcase
            k = chain + stride;
          end
          chain = k & mask;
          k = chain | (rand_key() & ~mask);
          lst = (j == blk_len - 1) && !(open_end && sent + blk_len >= PHASE_ITEMS);
          send_key(k, lst, 1'b0, '0);
        end
        sent += blk_len;
      end
    end
    burst = 1'b0;

    wait_idle();
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
